// ----- src/binary_row_run_length_store_unit_defines.svh -----
// ----------------------------------------------------------------------------
// binary_row_run_length_store_unit_defines.svh
// assertion macros used by the run-length store controller
// ----------------------------------------------------------------------------
`ifndef BINARY_ROW_RUN_LENGTH_STORE_UNIT_DEFINES_SVH
`define BINARY_ROW_RUN_LENGTH_STORE_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define BRLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brls assertion failed");

// next-cycle implication under reset
`define BRLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brls assertion failed");

`endif

// ----- src/brls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brls_pkg
// shared types and constants of the binary row run-length store
// ----------------------------------------------------------------------------
package brls_pkg;

    localparam logic [8:0] MAX_WIDTH  = 9'd256;
    localparam logic [8:0] MAX_HEIGHT = 9'd256;
    localparam logic [7:0] MAX_RUNS   = 8'd128;

    // request kinds
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ROW_ERR = 2'd1;
    localparam logic [1:0] ST_COL_ERR = 2'd2;
    localparam logic [1:0] ST_IDX_ERR = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_COLOR  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic       pixel_color;
        logic [6:0] found_index;
        logic       found;
        logic [8:0] run_length;
        logic [7:0] run_start;
        logic [7:0] run_row;
    } brls_res_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic load_exec;
        logic set_err;
        logic cnt_read;
        logic init;
        logic set_rd_bad;
        logic idx_read;
        logic set_rd_ok;
        logic mid_read;
        logic mid_update;
        logic last_read;
        logic set_query;
        logic set_nf;
        logic out_load;
    } brls_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       range_err;
        logic       load_close;
        logic       idx_ge_cnt;
        logic       lo_lt_hi;
        logic       lo_nz;
        logic       out_busy;
        logic       out_taken;
    } brls_stat_t;

endpackage

// ----- src/brls_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brls_ctrl
// sequencer for load, query search and run read
// ----------------------------------------------------------------------------
`include "binary_row_run_length_store_unit_defines.svh"

module brls_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  brls_pkg::brls_stat_t st,
    output brls_pkg::brls_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CWAIT  = 4'd2;
    localparam logic [3:0] S_RCHK   = 4'd3;
    localparam logic [3:0] S_RWAIT  = 4'd4;
    localparam logic [3:0] S_SEARCH = 4'd5;
    localparam logic [3:0] S_SWAIT  = 4'd6;
    localparam logic [3:0] S_LWAIT  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.req_type == brls_pkg::REQ_LOAD)
                begin
                    cmd.load_exec = 1'b1;
                    state_next    = st.load_close ? S_FIN : S_IDLE;
                end
                else if (st.req_type == brls_pkg::REQ_QUERY ||
                         st.req_type == brls_pkg::REQ_READ)
                begin
                    if (st.range_err)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        cmd.cnt_read = 1'b1;
                        state_next   = S_CWAIT;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CWAIT:
            begin
                cmd.init   = 1'b1;
                state_next = (st.req_type == brls_pkg::REQ_READ) ? S_RCHK : S_SEARCH;
            end
            S_RCHK:
            begin
                if (st.idx_ge_cnt)
                begin
                    cmd.set_rd_bad = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.idx_read = 1'b1;
                    state_next   = S_RWAIT;
                end
            end
            S_RWAIT:
            begin
                cmd.set_rd_ok = 1'b1;
                state_next    = S_FIN;
            end
            S_SEARCH:
            begin
                if (st.lo_lt_hi)
                begin
                    cmd.mid_read = 1'b1;
                    state_next   = S_SWAIT;
                end
                else if (st.lo_nz)
                begin
                    cmd.last_read = 1'b1;
                    state_next    = S_LWAIT;
                end
                else
                begin
                    cmd.set_nf = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_SWAIT:
            begin
                cmd.mid_update = 1'b1;
                state_next     = S_SEARCH;
            end
            S_LWAIT:
            begin
                cmd.set_query = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!st.out_busy || st.out_taken)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `BRLS_ASSERT_NOW(a_out_free, cmd.out_load, !st.out_busy || st.out_taken)
    `BRLS_ASSERT_NEXT(a_take_decode, s_tvalid && s_tready, state_reg == S_DECODE)
    `BRLS_ASSERT_NEXT(a_fin_hold, state_reg == S_FIN && st.out_busy && !st.out_taken,
        state_reg == S_FIN)

endmodule

// ----- src/brls_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brls_datapath
// load state, run count and run table memories, search bounds, result regs
// ----------------------------------------------------------------------------
module brls_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [8:0]           cfg_wdata,
    input  logic [1:0]           in_type,
    input  logic [23:0]          in_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output brls_pkg::brls_res_t  out_res,
    input  brls_pkg::brls_cmd_t  cmd,
    output brls_pkg::brls_stat_t st
);

    // configuration
    logic       color_reg;
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [8:0] w_eff;
    logic [8:0] h_eff;

    // latched request
    logic [1:0] type_reg;
    logic       bit_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic [6:0] idx_reg;

    // load state
    logic [7:0] col_reg;
    logic [7:0] row_reg;
    logic       inrun_reg;
    logic [7:0] ostart_reg;
    logic [7:0] cur_reg;

    // search
    logic [7:0]  cnt_reg;
    logic [7:0]  lo_reg;
    logic [7:0]  hi_reg;
    logic [7:0]  cnt_q_reg;
    logic        cnt_qv_reg;
    logic [7:0]  cnt_mem [256];
    logic [255:0] cnt_vld_reg;
    logic [16:0] tab_mem [32768];
    logic [16:0] tab_q_reg;

    brls_pkg::brls_res_t res_reg;
    brls_pkg::brls_res_t res_next;
    brls_pkg::brls_res_t out_reg;
    logic                out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg  <= 1'b1;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                brls_pkg::CFG_COLOR:  color_reg  <= cfg_wdata[0];
                brls_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                brls_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // clamp of image size
    assign w_eff = (width_reg == 9'd0) ? 9'd1 :
                   (width_reg > brls_pkg::MAX_WIDTH) ? brls_pkg::MAX_WIDTH : width_reg;
    assign h_eff = (height_reg == 9'd0) ? 9'd1 :
                   (height_reg > brls_pkg::MAX_HEIGHT) ? brls_pkg::MAX_HEIGHT : height_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            type_reg <= in_type;
            bit_reg  <= in_data[0];
            x_reg    <= in_data[8:1];
            y_reg    <= in_data[16:9];
            idx_reg  <= in_data[23:17];
        end
    end

    // pixel load step
    logic       l_first;
    logic [7:0] l_cur;
    logic       l_ir;
    logic       l_data;
    logic       l_last;
    logic [7:0] l_start;
    logic       l_inrun;
    logic       l_close;
    logic [8:0] l_len;
    logic       l_room;
    logic [7:0] l_cur_next;
    logic [8:0] l_row_inc;

    always_comb
    begin
        l_first    = (col_reg == 8'd0);
        l_cur      = l_first ? 8'd0 : cur_reg;
        l_ir       = l_first ? 1'b0 : inrun_reg;
        l_data     = (bit_reg == color_reg);
        l_last     = ({1'b0, col_reg} + 9'd1 >= w_eff);
        l_start    = (l_data && !l_ir) ? col_reg : ostart_reg;
        l_inrun    = l_ir || l_data;
        l_close    = l_inrun && (!l_data || l_last);
        l_len      = {1'b0, col_reg} - {1'b0, l_start} + {8'd0, l_data};
        l_room     = (l_cur < brls_pkg::MAX_RUNS);
        l_cur_next = (l_close && l_room) ? l_cur + 8'd1 : l_cur;
        l_row_inc  = {1'b0, row_reg} + 9'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= 8'd0;
            row_reg    <= 8'd0;
            inrun_reg  <= 1'b0;
            ostart_reg <= 8'd0;
            cur_reg    <= 8'd0;
        end
        else if (cmd.load_exec)
        begin
            ostart_reg <= l_start;
            cur_reg    <= l_cur_next;
            inrun_reg  <= l_inrun && !l_close && !l_last;
            if (l_last)
            begin
                col_reg <= 8'd0;
                row_reg <= (l_row_inc >= h_eff) ? 8'd0 : l_row_inc[7:0];
            end
            else
            begin
                col_reg <= col_reg + 8'd1;
            end
        end
    end

    // run count memory, valid bits stand for the zero reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_exec)
            cnt_mem[row_reg] <= l_cur_next;
        if (cmd.cnt_read)
            cnt_q_reg <= cnt_mem[y_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
            cnt_qv_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_exec)
                cnt_vld_reg[row_reg] <= 1'b1;
            if (cmd.cnt_read)
                cnt_qv_reg <= cnt_vld_reg[y_reg];
        end
    end

    // run table memory, one read port
    logic [7:0]  mid;
    logic [7:0]  lo_m1;
    logic [8:0]  lohi;
    logic [14:0] rd_addr;
    logic        rd_en;

    assign lohi  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid   = lohi[8:1];
    assign lo_m1 = lo_reg - 8'd1;
    assign rd_en = cmd.mid_read || cmd.last_read || cmd.idx_read;

    always_comb
    begin
        if (cmd.mid_read)
            rd_addr = {y_reg, mid[6:0]};
        else if (cmd.last_read)
            rd_addr = {y_reg, lo_m1[6:0]};
        else
            rd_addr = {y_reg, idx_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_exec && l_close && l_room)
            tab_mem[{row_reg, l_cur[6:0]}] <= {l_len, l_start};
        if (rd_en)
            tab_q_reg <= tab_mem[rd_addr];
    end

    // search bounds
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            cnt_reg <= cnt_qv_reg ? cnt_q_reg : 8'd0;
            lo_reg  <= 8'd0;
            hi_reg  <= cnt_qv_reg ? cnt_q_reg : 8'd0;
        end
        else if (cmd.mid_update)
        begin
            if (tab_q_reg[7:0] <= x_reg)
                lo_reg <= mid + 8'd1;
            else
                hi_reg <= mid;
        end
    end

    // result assembly
    logic [9:0] q_end;
    assign q_end = {2'b0, tab_q_reg[7:0]} + {1'b0, tab_q_reg[16:8]};

    always_comb
    begin
        res_next = res_reg;
        if (cmd.load_exec)
        begin
            res_next.run_row     = row_reg;
            res_next.run_start   = l_start;
            res_next.run_length  = l_len;
            res_next.found       = 1'b0;
            res_next.found_index = l_cur[6:0];
            res_next.pixel_color = 1'b0;
            res_next.status      = l_room ? brls_pkg::ST_OK : brls_pkg::ST_IDX_ERR;
        end
        else if (cmd.set_err)
        begin
            res_next         = '0;
            res_next.run_row = y_reg;
            if (type_reg == brls_pkg::REQ_READ)
                res_next.found_index = idx_reg;
            res_next.status  = ({1'b0, y_reg} >= h_eff) ? brls_pkg::ST_ROW_ERR
                                                        : brls_pkg::ST_COL_ERR;
        end
        else if (cmd.set_rd_bad || cmd.set_rd_ok)
        begin
            res_next             = '0;
            res_next.run_row     = y_reg;
            res_next.found_index = idx_reg;
            if (cmd.set_rd_ok)
            begin
                res_next.run_start  = tab_q_reg[7:0];
                res_next.run_length = tab_q_reg[16:8];
            end
            else
            begin
                res_next.status = brls_pkg::ST_IDX_ERR;
            end
        end
        else if (cmd.set_query || cmd.set_nf)
        begin
            res_next         = '0;
            res_next.run_row = y_reg;
            if (cmd.set_query && ({2'b0, x_reg} < q_end))
            begin
                res_next.run_start   = tab_q_reg[7:0];
                res_next.run_length  = tab_q_reg[16:8];
                res_next.found       = 1'b1;
                res_next.found_index = lo_m1[6:0];
                res_next.pixel_color = color_reg;
            end
            else
            begin
                res_next.pixel_color = ~color_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign out_res  = out_reg;

    // status to controller
    always_comb
    begin
        st.req_type   = type_reg;
        st.range_err  = ({1'b0, y_reg} >= h_eff) ||
                        (type_reg == brls_pkg::REQ_QUERY && {1'b0, x_reg} >= w_eff);
        st.load_close = l_close;
        st.idx_ge_cnt = ({1'b0, idx_reg} >= cnt_reg);
        st.lo_lt_hi   = (lo_reg < hi_reg);
        st.lo_nz      = (lo_reg != 8'd0);
        st.out_busy   = out_valid_reg;
        st.out_taken  = m_tready;
    end

endmodule

// ----- src/binary_row_run_length_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_row_run_length_store_unit
// per-row run-length store of a one-bit raster image with query and read
// ----------------------------------------------------------------------------
// A load beat that closes a run hands a result to the output register. A query
// runs a binary search over the stored runs of its row, at most 128, which makes
// one registered read of the run table memory per step, and then fetches the
// final run. Results sit in an output register, so the next beat is taken while
// a result waits. Run table entries never written read as undefined.
module binary_row_run_length_store_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // pixel_bit, query_x, query_y, run_index
    input  logic [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // run_row, run_start, run_length, found,
                                  // found_index, pixel_color, status, zero pad
);

    brls_pkg::brls_cmd_t  cmd;
    brls_pkg::brls_stat_t st;
    brls_pkg::brls_res_t  res;

    brls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    brls_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_type   (s_tuser),
        .in_data   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_res   (res),
        .cmd       (cmd),
        .st        (st)
    );

    // result packing, first field lowest
    assign m_tdata = {4'd0, res};

endmodule

// ----- bench/tb_binary_row_run_length_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_row_run_length_store_unit
// self-checking bench for the binary row run-length store
// ----------------------------------------------------------------------------
// Loads small one-bit images in raster order and mixes in pixel queries and
// stored-run reads. A predictor tracks the per-row run tables and builds the
// expected result of each accepted beat that gives one. Results are compared in
// order, field by field. Image size and data color change between phases while
// the block is idle; the values include zero, the largest 9-bit value and
// mid-row width changes. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_binary_row_run_length_store_unit;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         SETTLE     = 40;

    typedef struct {
        logic [1:0] kind;
        logic       pix;
        logic [7:0] qx;
        logic [7:0] qy;
        logic [6:0] ri;
    } req_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    binary_row_run_length_store_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor copy of registers and image state
    logic       pm_color;
    logic [8:0] pm_width;
    logic [8:0] pm_height;
    logic [7:0] pm_col;
    logic [7:0] pm_row;
    logic       pm_inside;
    logic [7:0] pm_open;
    logic [7:0] pm_count [0:255];
    logic [7:0] pm_start [0:32767];
    logic [8:0] pm_len   [0:32767];

    req_beat_t            pending_beats [$];
    brls_pkg::brls_res_t  expected_runs [$];
    req_beat_t            cur_beat;
    bit                   took;
    int                   snd_idle;
    int                   rcv_idle;
    int                   errors;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("binary_row_run_length_store_unit regression: fail");
        $finish;
    end

    function automatic int width_now();
        if (pm_width < 9'd1) return 1;
        if (pm_width > brls_pkg::MAX_WIDTH) return int'(brls_pkg::MAX_WIDTH);
        return int'(pm_width);
    endfunction

    function automatic int height_now();
        if (pm_height < 9'd1) return 1;
        if (pm_height > brls_pkg::MAX_HEIGHT) return int'(brls_pkg::MAX_HEIGHT);
        return int'(pm_height);
    endfunction

    function automatic brls_pkg::brls_res_t pack_run(int row, int start, int len, int fnd,
                                                     int idx, int color, logic [1:0] st);
        brls_pkg::brls_res_t r;
        r.run_row     = row[7:0];
        r.run_start   = start[7:0];
        r.run_length  = len[8:0];
        r.found       = fnd[0];
        r.found_index = idx[6:0];
        r.pixel_color = color[0];
        r.status      = st;
        return r;
    endfunction

    // expected result of one accepted beat
    task automatic predict_beat(input req_beat_t b);
        int w, h, row, col, len, cnt, lo, hi, mid, base, s, l;
        bit is_data, last, close;
        w = width_now();
        h = height_now();
        case (b.kind)
            brls_pkg::REQ_LOAD:
            begin
                row = pm_row;
                col = pm_col;
                is_data = (b.pix == pm_color);
                last = (col + 1 >= w);
                close = 0;
                len = 0;
                if (col == 0)
                begin
                    pm_count[row] = 8'd0;
                    pm_inside = 1'b0;
                end
                if (is_data && !pm_inside)
                begin
                    pm_inside = 1'b1;
                    pm_open = col[7:0];
                end
                if (pm_inside)
                begin
                    if (!is_data)
                    begin
                        close = 1;
                        len = col - pm_open;
                    end
                    else if (last)
                    begin
                        close = 1;
                        len = col - pm_open + 1;
                    end
                end
                if (close)
                begin
                    cnt = pm_count[row];
                    pm_inside = 1'b0;
                    if (cnt < int'(brls_pkg::MAX_RUNS))
                    begin
                        pm_start[row * 128 + cnt] = pm_open;
                        pm_len[row * 128 + cnt] = len[8:0];
                        pm_count[row] = cnt[7:0] + 8'd1;
                        expected_runs.push_back(pack_run(row, pm_open, len, 0, cnt, 0,
                                                         brls_pkg::ST_OK));
                    end
                    else
                        expected_runs.push_back(pack_run(row, pm_open, len, 0, cnt, 0,
                                                         brls_pkg::ST_IDX_ERR));
                end
                if (last)
                begin
                    pm_col = 8'd0;
                    pm_inside = 1'b0;
                    pm_row = (row + 1 >= h) ? 8'd0 : pm_row + 8'd1;
                end
                else
                    pm_col = pm_col + 8'd1;
            end
            brls_pkg::REQ_QUERY:
            begin
                if (b.qy >= h)
                    expected_runs.push_back(pack_run(b.qy, 0, 0, 0, 0, 0,
                                                     brls_pkg::ST_ROW_ERR));
                else if (b.qx >= w)
                    expected_runs.push_back(pack_run(b.qy, 0, 0, 0, 0, 0,
                                                     brls_pkg::ST_COL_ERR));
                else
                begin
                    // last stored start not above the column
                    lo = 0;
                    hi = pm_count[b.qy];
                    base = b.qy * 128;
                    while (lo < hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (pm_start[base + mid] <= b.qx) lo = mid + 1;
                        else hi = mid;
                    end
                    s = 0;
                    l = 0;
                    if (lo > 0)
                    begin
                        s = pm_start[base + lo - 1];
                        l = pm_len[base + lo - 1];
                    end
                    if (lo > 0 && b.qx < s + l)
                        expected_runs.push_back(pack_run(b.qy, s, l, 1, lo - 1, pm_color,
                                                         brls_pkg::ST_OK));
                    else
                        expected_runs.push_back(pack_run(b.qy, 0, 0, 0, 0, !pm_color,
                                                         brls_pkg::ST_OK));
                end
            end
            brls_pkg::REQ_READ:
            begin
                if (b.qy >= h)
                    expected_runs.push_back(pack_run(b.qy, 0, 0, 0, b.ri, 0,
                                                     brls_pkg::ST_ROW_ERR));
                else if (b.ri >= pm_count[b.qy])
                    expected_runs.push_back(pack_run(b.qy, 0, 0, 0, b.ri, 0,
                                                     brls_pkg::ST_IDX_ERR));
                else
                    expected_runs.push_back(pack_run(b.qy, pm_start[b.qy * 128 + b.ri],
                                                     pm_len[b.qy * 128 + b.ri], 0, b.ri, 0,
                                                     brls_pkg::ST_OK));
            end
            default: ;
        endcase
    endtask

    // acceptance of input beats
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            took = 1'b1;
            predict_beat(cur_beat);
        end
    end

    // driver and receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took || !s_tvalid)
            begin
                if (pending_beats.size() > 0 && $urandom_range(0, 99) >= snd_idle)
                begin
                    cur_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_beat.ri, cur_beat.qy, cur_beat.qx, cur_beat.pix};
                    s_tuser  <= cur_beat.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
            took = 1'b0;
            m_tready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        brls_pkg::brls_res_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = brls_pkg::brls_res_t'(m_tdata[35:0]);
            if (expected_runs.size() == 0)
            begin
                $error("unexpected result beat %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_runs.pop_front();
                if (got.run_row !== want.run_row)
                begin
                    $error("run_row exp %0d got %0d", want.run_row, got.run_row);
                    errors++;
                end
                if (got.run_start !== want.run_start)
                begin
                    $error("run_start exp %0d got %0d", want.run_start, got.run_start);
                    errors++;
                end
                if (got.run_length !== want.run_length)
                begin
                    $error("run_length exp %0d got %0d", want.run_length, got.run_length);
                    errors++;
                end
                if (got.found !== want.found)
                begin
                    $error("found exp %0d got %0d", want.found, got.found);
                    errors++;
                end
                if (got.found_index !== want.found_index)
                begin
                    $error("found_index exp %0d got %0d", want.found_index, got.found_index);
                    errors++;
                end
                if (got.pixel_color !== want.pixel_color)
                begin
                    $error("pixel_color exp %0d got %0d", want.pixel_color, got.pixel_color);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    function automatic void add_beat(logic [1:0] kind, logic pix, logic [7:0] qx,
                                     logic [7:0] qy, logic [6:0] ri);
        req_beat_t b;
        b.kind = kind;
        b.pix  = pix;
        b.qx   = qx;
        b.qy   = qy;
        b.ri   = ri;
        pending_beats.push_back(b);
    endfunction

    task automatic write_reg(input logic [1:0] addr, input logic [8:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            brls_pkg::CFG_COLOR:  pm_color = value[0];
            brls_pkg::CFG_WIDTH:  pm_width = value;
            brls_pkg::CFG_HEIGHT: pm_height = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender holds off until the block has drained
    task automatic drain();
        while (pending_beats.size() > 0 || s_tvalid || expected_runs.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random mix: load bursts with sticky pixels, queries, reads, some noise
    task automatic random_phase(input int n);
        int made, r, burst, w, h;
        logic pix;
        w = width_now();
        h = height_now();
        made = 0;
        pix = $urandom_range(0, 1);
        while (made < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                burst = $urandom_range(1, (w > 32) ? 32 : w);
                repeat (burst)
                begin
                    if ($urandom_range(0, 99) < 35) pix = !pix;
                    add_beat(brls_pkg::REQ_LOAD, pix, $urandom, $urandom, $urandom);
                end
                made += burst;
            end
            else if (r < 75)
            begin
                if ($urandom_range(0, 9) < 8)
                    add_beat(brls_pkg::REQ_QUERY, $urandom, $urandom_range(0, w - 1),
                             $urandom_range(0, h - 1), $urandom);
                else
                    add_beat(brls_pkg::REQ_QUERY, $urandom, $urandom, $urandom, $urandom);
                made++;
            end
            else if (r < 96)
            begin
                if ($urandom_range(0, 9) < 8)
                    add_beat(brls_pkg::REQ_READ, $urandom, $urandom,
                             $urandom_range(0, h - 1), $urandom_range(0, 7));
                else
                    add_beat(brls_pkg::REQ_READ, $urandom, $urandom, $urandom, $urandom);
                made++;
            end
            else
                add_beat(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // stimulus
    initial
    begin
        int i;
        logic [8:0] w_list [0:9];
        logic [8:0] h_list [0:9];
        w_list = '{9'd3, 9'd1, 9'd8, 9'd0, 9'd2, 9'd511, 9'd16, 9'd5, 9'd300, 9'd6};
        h_list = '{9'd4, 9'd2, 9'd1, 9'd3, 9'd0, 9'd6, 9'd511, 9'd8, 9'd2, 9'd5};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = brls_pkg::CFG_COLOR;
        cfg_wdata = 9'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 24'd0;
        s_tuser   = brls_pkg::REQ_LOAD;
        m_tready  = 1'b0;
        took      = 1'b0;
        errors    = 0;
        snd_idle  = 26;
        rcv_idle  = 85;
        pm_color  = 1'b1;
        pm_width  = 9'd256;
        pm_height = 9'd256;
        pm_col    = 8'd0;
        pm_row    = 8'd0;
        pm_inside = 1'b0;
        pm_open   = 8'd0;
        for (i = 0; i < 256; i++) pm_count[i] = 8'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store at reset size
        add_beat(brls_pkg::REQ_QUERY, 1'b0, 8'd255, 8'd255, 7'd0);
        add_beat(brls_pkg::REQ_READ, 1'b0, 8'd0, 8'd255, 7'd127);
        drain();

        // directed 4x3 image: two runs, an empty row, a full-width run
        write_reg(brls_pkg::CFG_WIDTH, 9'd4);
        write_reg(brls_pkg::CFG_HEIGHT, 9'd3);
        write_reg(brls_pkg::CFG_COLOR, 9'd1);
        add_beat(brls_pkg::REQ_LOAD, 1'b1, 8'd0, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_LOAD, 1'b1, 8'd0, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_LOAD, 1'b0, 8'd0, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_LOAD, 1'b1, 8'd0, 8'd0, 7'd0);
        repeat (4) add_beat(brls_pkg::REQ_LOAD, 1'b0, 8'd0, 8'd0, 7'd0);
        repeat (4) add_beat(brls_pkg::REQ_LOAD, 1'b1, 8'd0, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_QUERY, 1'b0, 8'd1, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_QUERY, 1'b0, 8'd2, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_QUERY, 1'b0, 8'd3, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_QUERY, 1'b0, 8'd0, 8'd3, 7'd0);
        add_beat(brls_pkg::REQ_QUERY, 1'b0, 8'd4, 8'd2, 7'd0);
        add_beat(brls_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 7'd1);
        add_beat(brls_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 7'd2);
        add_beat(brls_pkg::REQ_READ, 1'b0, 8'd0, 8'd5, 7'd0);
        add_beat(REQ_UNUSED, 1'b1, 8'd255, 8'd255, 7'd127);
        // image end wraps to row 0
        add_beat(brls_pkg::REQ_LOAD, 1'b1, 8'd0, 8'd0, 7'd0);
        drain();

        // dense row of alternating pixels at full width, left mid-row
        write_reg(brls_pkg::CFG_WIDTH, 9'd256);
        write_reg(brls_pkg::CFG_HEIGHT, 9'd1);
        write_reg(brls_pkg::CFG_COLOR, 9'd0);
        for (i = 0; i < 256; i++) add_beat(brls_pkg::REQ_LOAD, i[0], 8'd0, 8'd0, 7'd0);
        for (i = 0; i < 200; i++) add_beat(brls_pkg::REQ_LOAD, $urandom, 8'd0, 8'd0, 7'd0);
        for (i = 0; i < 12; i++)
            add_beat(brls_pkg::REQ_QUERY, 1'b0, $urandom, 8'd0, 7'd0);
        add_beat(brls_pkg::REQ_READ, 1'b0, 8'd0, 8'd0, 7'd127);
        drain();

        for (i = 0; i < 10; i++)
        begin
            if (i == 4)
            begin
                snd_idle = 85;
                rcv_idle = 26;
            end
            if (i == 7)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_reg(brls_pkg::CFG_WIDTH, w_list[i]);
            write_reg(brls_pkg::CFG_HEIGHT, h_list[i]);
            write_reg(brls_pkg::CFG_COLOR, {8'd0, i[0]});
            random_phase(60);
            drain();
        end

        if (errors == 0)
            $display("binary_row_run_length_store_unit regression: pass");
        else
            $display("binary_row_run_length_store_unit regression: fail");
        $finish;
    end

endmodule
